// File: src/ikp_pkg.sv
// shared constants, types and the arctangent table of the two-link arm solver
package ikp_pkg;

   localparam int ANG_BITS          = 30;
   localparam int ANGLE_W           = 36;
   localparam int DEF_CORDIC_STAGES = 18;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int LINK_W     = 17;
   localparam int COORD_W    = 19;
   localparam int SHOULDER_W = 20;
   localparam int ELBOW_W    = 18;
   localparam int CSR_ADDR_W = 2;

   localparam int DEN_W  = 35;
   localparam int C_W    = 32;
   localparam int ROOT_W = 31;

   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER_LINK = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER_LINK = 2'd1;

   localparam logic [LINK_W-1:0] UPPER_LINK_RESET = 17'd29491;
   localparam logic [LINK_W-1:0] LOWER_LINK_RESET = 17'd31457;

   localparam logic signed [ANGLE_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

   typedef struct packed {
      logic                      neg;
      logic                      sat;
      logic                      flag;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } div_tag_type;

   typedef struct packed {
      logic signed [C_W-1:0]     c;
      logic                      flag;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } sqrt_tag_type;

   typedef struct packed {
      logic signed [SHOULDER_W-1:0] shoulder;
      logic [ELBOW_W-1:0]           elbow;
      logic                         flag;
   } rsp_type;

   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         24: v = 32'h0000003F;
         25: v = 32'h0000001F;
         26: v = 32'h0000000F;
         27: v = 32'h00000008;
         28: v = 32'h00000004;
         29: v = 32'h00000002;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// File: src/ikp_div.sv
// pipelined restoring divider, one quotient bit per stage
module ikp_div #(
   parameter int DEN_W = 35,
   parameter int Q_W   = 30,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [DEN_W-1:0] den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_q,
   output logic [TAG_W-1:0] out_tag
);

   logic [Q_W:1]     valid_ff;
   logic [DEN_W-1:0] rem_ff [1:Q_W];
   logic [Q_W-1:0]   q_ff   [1:Q_W];
   logic [TAG_W-1:0] tag_ff [1:Q_W];

   logic [Q_W-1:0]   valid_src;
   logic [DEN_W-1:0] rem_src [0:Q_W-1];
   logic [Q_W-1:0]   q_src   [0:Q_W-1];
   logic [TAG_W-1:0] tag_src [0:Q_W-1];
   logic [DEN_W-1:0] rem_in  [0:Q_W-1];
   logic [Q_W-1:0]   q_in    [0:Q_W-1];

   always_comb begin
      logic [DEN_W:0] sh;
      logic [DEN_W:0] dif;
      logic           take;
      valid_src[0] = in_valid;
      rem_src[0]   = in_rem;
      q_src[0]     = '0;
      tag_src[0]   = in_tag;
      for (int k = 1; k < Q_W; k++) begin
         valid_src[k] = valid_ff[k];
         rem_src[k]   = rem_ff[k];
         q_src[k]     = q_ff[k];
         tag_src[k]   = tag_ff[k];
      end
      for (int k = 0; k < Q_W; k++) begin
         sh        = {rem_src[k], 1'b0};
         dif       = sh - {1'b0, den};
         take      = (sh >= {1'b0, den});
         rem_in[k] = take ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
         q_in[k]   = {q_src[k][Q_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         for (int k = 0; k < Q_W; k++) valid_ff[k+1] <= valid_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Q_W; k++) begin
            rem_ff[k+1] <= rem_in[k];
            q_ff[k+1]   <= q_in[k];
            tag_ff[k+1] <= tag_src[k];
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_q     = q_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];

endmodule

// File: src/ikp_sqrt.sv
// pipelined floor square root, one root bit per stage
module ikp_sqrt #(
   parameter int ROOT_W = 31,
   parameter int TAG_W  = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_rad,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int RAD_W = 2 * ROOT_W;

   logic [ROOT_W:1]   valid_ff;
   logic [RAD_W-1:0]  rad_ff  [1:ROOT_W];
   logic [ROOT_W+1:0] rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff [1:ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [1:ROOT_W];

   logic [ROOT_W-1:0] valid_src;
   logic [RAD_W-1:0]  rad_src  [0:ROOT_W-1];
   logic [ROOT_W+1:0] rem_src  [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_src [0:ROOT_W-1];
   logic [TAG_W-1:0]  tag_src  [0:ROOT_W-1];
   logic [RAD_W-1:0]  rad_in   [0:ROOT_W-1];
   logic [ROOT_W+1:0] rem_in   [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_in  [0:ROOT_W-1];

   always_comb begin
      logic [ROOT_W+1:0] shifted;
      logic [ROOT_W+1:0] trial;
      logic              take;
      valid_src[0] = in_valid;
      rad_src[0]   = in_rad;
      rem_src[0]   = '0;
      root_src[0]  = '0;
      tag_src[0]   = in_tag;
      for (int k = 1; k < ROOT_W; k++) begin
         valid_src[k] = valid_ff[k];
         rad_src[k]   = rad_ff[k];
         rem_src[k]   = rem_ff[k];
         root_src[k]  = root_ff[k];
         tag_src[k]   = tag_ff[k];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         shifted    = {rem_src[k][ROOT_W-1:0], rad_src[k][RAD_W-1 -: 2]};
         trial      = {root_src[k], 2'b01};
         take       = (shifted >= trial);
         rem_in[k]  = take ? (shifted - trial) : shifted;
         root_in[k] = {root_src[k][ROOT_W-2:0], take};
         rad_in[k]  = {rad_src[k][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         for (int k = 0; k < ROOT_W; k++) valid_ff[k+1] <= valid_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rad_ff[k+1]  <= rad_in[k];
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
            tag_ff[k+1]  <= tag_src[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];

endmodule

// File: src/ikp_cordic.sv
// pipelined vectoring cordic, angle of (x, y) in q30 radians
module ikp_cordic #(
   parameter int W      = 34,
   parameter int STAGES = ikp_pkg::DEF_CORDIC_STAGES
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [W-1:0]                in_x,
   input  logic signed [W-1:0]                in_y,
   output logic signed [ikp_pkg::ANGLE_W-1:0] out_z
);

   localparam int AW = ikp_pkg::ANGLE_W;

   logic signed [W-1:0]  x_ff [0:STAGES];
   logic signed [W-1:0]  y_ff [0:STAGES];
   logic signed [AW-1:0] z_ff [0:STAGES];
   logic [STAGES:0]      fix_ff;
   logic [STAGES:0]      fixpi_ff;

   logic signed [W-1:0]  x0_in;
   logic signed [W-1:0]  y0_in;
   logic signed [AW-1:0] z0_in;
   logic signed [W-1:0]  x_in [0:STAGES-1];
   logic signed [W-1:0]  y_in [0:STAGES-1];
   logic signed [AW-1:0] z_in [0:STAGES-1];

   // quadrant fold into the right half plane
   always_comb begin
      if (in_x < 0 && in_y > 0) begin
         x0_in = in_y;
         y0_in = -in_x;
         z0_in = ikp_pkg::HALF_PI_Q30;
      end else if (in_x < 0) begin
         x0_in = -in_y;
         y0_in = in_x;
         z0_in = -ikp_pkg::HALF_PI_Q30;
      end else begin
         x0_in = in_x;
         y0_in = in_y;
         z0_in = '0;
      end
   end

   always_comb begin
      logic signed [W-1:0]  dx;
      logic signed [W-1:0]  dy;
      logic signed [AW-1:0] da;
      for (int k = 0; k < STAGES; k++) begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         da = $signed(AW'(ikp_pkg::atan_q30(k)));
         if (y_ff[k] > 0) begin
            x_in[k] = x_ff[k] + dx;
            y_in[k] = y_ff[k] - dy;
            z_in[k] = z_ff[k] + da;
         end else begin
            x_in[k] = x_ff[k] - dx;
            y_in[k] = y_ff[k] + dy;
            z_in[k] = z_ff[k] - da;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]     <= x0_in;
         y_ff[0]     <= y0_in;
         z_ff[0]     <= z0_in;
         fix_ff[0]   <= (in_y == 0);
         fixpi_ff[0] <= (in_x < 0);
         for (int k = 0; k < STAGES; k++) begin
            x_ff[k+1]     <= x_in[k];
            y_ff[k+1]     <= y_in[k];
            z_ff[k+1]     <= z_in[k];
            fix_ff[k+1]   <= fix_ff[k];
            fixpi_ff[k+1] <= fixpi_ff[k];
         end
      end
   end

   // zero y resolves to 0 or pi without iterating
   assign out_z = fix_ff[STAGES] ? (fixpi_ff[STAGES] ? ikp_pkg::PI_Q30 : '0) : z_ff[STAGES];

endmodule

// File: src/ikp_skid.sv
// two-entry output buffer with registered room flag
module ikp_skid #(
   parameter int W = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  logic [W-1:0] push_data,
   output logic         room,
   output logic         pop_valid,
   input  logic         pop_ready,
   output logic [W-1:0] pop_data
);

   logic [1:0]   count_ff, count_in;
   logic         room_ff, room_in;
   logic [W-1:0] head_ff, head_in;
   logic [W-1:0] tail_ff, tail_in;
   logic         pop;

   always_comb begin
      pop      = (count_ff != 2'd0) && pop_ready;
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push_valid, pop})
         2'b10: begin
            if (count_ff == 2'd0) head_in = push_data;
            else tail_in = push_data;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: ;
      endcase
      room_in = (count_in != 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         room_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         room_ff  <= room_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign room      = room_ff;
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = head_ff;

endmodule

// File: src/two_link_planar_inverse_kinematics.sv
// top level of the two-link planar arm inverse kinematics solver
//
// req channel: one beat carries a hand target x, y in signed q3.16 metres.
// rsp channel: one beat per target with shoulder angle, elbow angle and the
//   out-of-reach flag; angles are rounded to FRACTION_BITS fraction bits.
// csr channel: index 0 writes the upper link length, index 1 the lower one,
//   other indexes are dropped; csr_ready is always high. write only while idle.
// throughput: one target per cycle while the output buffer has room, fully pipelined.
// datapath: a req beat passes the 30-stage divider for the elbow cosine,
//   the 31-stage square root and the cordic stages on its way to the rsp beat.
// reset: clears the pipeline valid bits and the output buffer, loads link
//   lengths 0.45 m and 0.48 m; req_ready is low during reset and in the cycle after it.
// stall: a two-entry output buffer holds finished results; while it is full
//   the whole pipeline freezes and req_ready goes low, nothing is lost.
module two_link_planar_inverse_kinematics #(
   parameter int CORDIC_STAGES = ikp_pkg::DEF_CORDIC_STAGES,
   parameter int FRACTION_BITS = ikp_pkg::DEF_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ikp_pkg::COORD_W-1:0]    req_target_x,
   input  logic signed [ikp_pkg::COORD_W-1:0]    req_target_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ikp_pkg::SHOULDER_W-1:0] rsp_shoulder_angle,
   output logic [ikp_pkg::ELBOW_W-1:0]           rsp_elbow_angle,
   output logic                                  rsp_out_of_reach,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ikp_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [ikp_pkg::LINK_W-1:0]            csr_data
);

   localparam int AW    = ikp_pkg::ANGLE_W;
   localparam int CW    = ikp_pkg::COORD_W;
   localparam int LW    = ikp_pkg::LINK_W;
   localparam int RW    = ikp_pkg::ROOT_W;
   localparam int DW    = ikp_pkg::DEN_W;
   localparam int QW    = ikp_pkg::ANG_BITS;
   localparam int LAT_C = CORDIC_STAGES + 1;
   localparam int SH    = ikp_pkg::ANG_BITS - FRACTION_BITS;
   localparam int W_A   = 34;
   localparam int W_B   = 42;
   localparam int W_C   = 52;
   localparam logic signed [AW-1:0] RND = (36'sd1 <<< SH) >>> 1;

   logic en;

   // link length registers and their products
   logic [LW-1:0]   upper_link_ff, lower_link_ff;
   logic [2*LW-1:0] l1sq_ff, l2sq_ff, l1l2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_link_ff <= ikp_pkg::UPPER_LINK_RESET;
         lower_link_ff <= ikp_pkg::LOWER_LINK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ikp_pkg::CSR_UPPER_LINK: upper_link_ff <= csr_data;
            ikp_pkg::CSR_LOWER_LINK: lower_link_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      l1sq_ff <= upper_link_ff * upper_link_ff;
      l2sq_ff <= lower_link_ff * lower_link_ff;
      l1l2_ff <= upper_link_ff * lower_link_ff;
   end

   logic [DW-1:0] den;
   assign den = {l1l2_ff, 1'b0};

   // stage 1: squares of the target
   logic                 s1_valid_ff;
   logic signed [CW-1:0] s1_x_ff, s1_y_ff;
   logic [2*CW-2:0]      s1_xx_ff, s1_yy_ff;
   logic signed [2*CW-1:0] xx_in, yy_in;

   assign xx_in = req_target_x * req_target_x;
   assign yy_in = req_target_y * req_target_y;

   // stage 2: cosine numerator
   logic                 s2_valid_ff;
   logic signed [CW-1:0] s2_x_ff, s2_y_ff;
   logic signed [2*CW:0] s2_num_ff, num_in;

   assign num_in = $signed({2'b00, s1_xx_ff}) + $signed({2'b00, s1_yy_ff})
                 - $signed({5'b00000, l1sq_ff}) - $signed({5'b00000, l2sq_ff});

   // stage 3: magnitude and range check
   logic                  s3_valid_ff;
   logic [DW-1:0]         s3_rem_ff;
   ikp_pkg::div_tag_type  s3_tag_ff, s3_tag_in;
   logic signed [2*CW:0]  neg_num;
   logic [2*CW-1:0]       mag_in;

   always_comb begin
      neg_num        = -s2_num_ff;
      mag_in         = s2_num_ff[2*CW] ? neg_num[2*CW-1:0] : s2_num_ff[2*CW-1:0];
      s3_tag_in.neg  = s2_num_ff[2*CW];
      s3_tag_in.sat  = (mag_in >= {3'b000, den});
      s3_tag_in.flag = (mag_in > {3'b000, den});
      s3_tag_in.x    = s2_x_ff;
      s3_tag_in.y    = s2_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff   <= req_target_x;
         s1_y_ff   <= req_target_y;
         s1_xx_ff  <= xx_in[2*CW-2:0];
         s1_yy_ff  <= yy_in[2*CW-2:0];
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_num_ff <= num_in;
         s3_rem_ff <= mag_in[DW-1:0];
         s3_tag_ff <= s3_tag_in;
      end
   end

   // cosine quotient
   logic                                    div_valid;
   logic [QW-1:0]                           div_q;
   logic [$bits(ikp_pkg::div_tag_type)-1:0] div_tag_vec;
   ikp_pkg::div_tag_type                    div_tag;

   ikp_div #(
      .DEN_W (DW),
      .Q_W   (QW),
      .TAG_W ($bits(ikp_pkg::div_tag_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rem    (s3_rem_ff),
      .den       (den),
      .in_tag    (s3_tag_ff),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_tag   (div_tag_vec)
   );

   assign div_tag = ikp_pkg::div_tag_type'(div_tag_vec);

   // c1: signed cosine, c2: square, c3: radicand
   logic                  c1_valid_ff, c2_valid_ff, c3_valid_ff;
   logic [RW-1:0]         c1_ca_ff, ca_in;
   ikp_pkg::sqrt_tag_type c1_tag_ff, c2_tag_ff, c3_tag_ff, c1_tag_in;
   logic [2*RW-1:0]       c2_sq_ff, c3_rad_ff;

   always_comb begin
      ca_in          = div_tag.sat ? (31'd1 << QW) : {1'b0, div_q};
      c1_tag_in.c    = div_tag.neg ? -$signed({1'b0, ca_in}) : $signed({1'b0, ca_in});
      c1_tag_in.flag = div_tag.flag;
      c1_tag_in.x    = div_tag.x;
      c1_tag_in.y    = div_tag.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else if (en) begin
         c1_valid_ff <= div_valid;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ca_ff  <= ca_in;
         c1_tag_ff <= c1_tag_in;
         c2_sq_ff  <= c1_ca_ff * c1_ca_ff;
         c2_tag_ff <= c1_tag_ff;
         c3_rad_ff <= (62'd1 << (2 * QW)) - c2_sq_ff;
         c3_tag_ff <= c2_tag_ff;
      end
   end

   // sine from the square root
   logic                                     sq_valid;
   logic [RW-1:0]                            sq_root;
   logic [$bits(ikp_pkg::sqrt_tag_type)-1:0] sq_tag_vec;
   ikp_pkg::sqrt_tag_type                    sq_tag;

   ikp_sqrt #(
      .ROOT_W (RW),
      .TAG_W  ($bits(ikp_pkg::sqrt_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c3_valid_ff),
      .in_rad    (c3_rad_ff),
      .in_tag    (c3_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag_vec)
   );

   assign sq_tag = ikp_pkg::sqrt_tag_type'(sq_tag_vec);

   // p1: link products, p2: forearm vector
   logic                     p1_valid_ff, p2_valid_ff;
   logic [RW-1:0]            p1_s_ff, p2_s_ff;
   logic signed [QW+1:0]     p1_c_ff, p2_c_ff;
   logic                     p1_flag_ff, p2_flag_ff;
   logic signed [CW-1:0]     p1_x_ff, p1_y_ff, p2_x_ff, p2_y_ff;
   logic [LW+RW-1:0]         p1_ps_ff, p2_yc_ff;
   logic signed [LW+RW:0]    p1_pc_ff, p2_xc_ff;
   logic signed [LW+RW+1:0]  pc_in;

   assign pc_in = $signed({1'b0, lower_link_ff}) * sq_tag.c;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= sq_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_s_ff    <= sq_root;
         p1_c_ff    <= sq_tag.c;
         p1_flag_ff <= sq_tag.flag;
         p1_x_ff    <= sq_tag.x;
         p1_y_ff    <= sq_tag.y;
         p1_ps_ff   <= lower_link_ff * sq_root;
         p1_pc_ff   <= pc_in[LW+RW:0];
         p2_s_ff    <= p1_s_ff;
         p2_c_ff    <= p1_c_ff;
         p2_flag_ff <= p1_flag_ff;
         p2_x_ff    <= p1_x_ff;
         p2_y_ff    <= p1_y_ff;
         p2_yc_ff   <= p1_ps_ff;
         p2_xc_ff   <= $signed({2'b00, upper_link_ff, 30'd0}) + p1_pc_ff;
      end
   end

   // three angle units side by side
   logic signed [AW-1:0] za, zb, zc;

   ikp_cordic #(
      .W      (W_A),
      .STAGES (CORDIC_STAGES)
   ) u_cordic_elbow (
      .clock (clock),
      .en    (en),
      .in_x  ({{2{p2_c_ff[QW+1]}}, p2_c_ff}),
      .in_y  ({3'b000, p2_s_ff}),
      .out_z (za)
   );

   ikp_cordic #(
      .W      (W_B),
      .STAGES (CORDIC_STAGES)
   ) u_cordic_target (
      .clock (clock),
      .en    (en),
      .in_x  ({{3{p2_x_ff[CW-1]}}, p2_x_ff, 20'd0}),
      .in_y  ({{3{p2_y_ff[CW-1]}}, p2_y_ff, 20'd0}),
      .out_z (zb)
   );

   ikp_cordic #(
      .W      (W_C),
      .STAGES (CORDIC_STAGES)
   ) u_cordic_link (
      .clock (clock),
      .en    (en),
      .in_x  ({{3{p2_xc_ff[LW+RW]}}, p2_xc_ff}),
      .in_y  ({4'b0000, p2_yc_ff}),
      .out_z (zc)
   );

   logic [LAT_C-1:0] d_valid_ff, d_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= '0;
      end else if (en) begin
         d_valid_ff <= {d_valid_ff[LAT_C-2:0], p2_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) d_flag_ff <= {d_flag_ff[LAT_C-2:0], p2_flag_ff};
   end

   // f1: joint angles in q30
   logic                 f1_valid_ff, f1_flag_ff;
   logic signed [AW-1:0] f1_t1_ff, f1_t2_ff, t1_in, t2_in;

   always_comb begin
      t1_in = ikp_pkg::HALF_PI_Q30 - zb - zc;
      if (za < 0) t2_in = '0;
      else if (za > ikp_pkg::PI_Q30) t2_in = ikp_pkg::PI_Q30;
      else t2_in = za;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= d_valid_ff[LAT_C-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_t1_ff   <= t1_in;
         f1_t2_ff   <= t2_in;
         f1_flag_ff <= d_flag_ff[LAT_C-1];
      end
   end

   // round half up to the output format
   logic signed [AW-1:0] t1_rnd, t2_rnd;
   ikp_pkg::rsp_type     push_data, pop_data;

   always_comb begin
      t1_rnd             = (f1_t1_ff + RND) >>> SH;
      t2_rnd             = (f1_t2_ff + RND) >>> SH;
      push_data.shoulder = t1_rnd[ikp_pkg::SHOULDER_W-1:0];
      push_data.elbow    = t2_rnd[ikp_pkg::ELBOW_W-1:0];
      push_data.flag     = f1_flag_ff;
   end

   ikp_skid #(
      .W ($bits(ikp_pkg::rsp_type))
   ) u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f1_valid_ff && en),
      .push_data  (push_data),
      .room       (en),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (pop_data)
   );

   assign req_ready          = en;
   assign rsp_shoulder_angle = pop_data.shoulder;
   assign rsp_elbow_angle    = pop_data.elbow;
   assign rsp_out_of_reach   = pop_data.flag;

endmodule

// File: src/ikp_checker.sv
// port-level checks of the arm solver and their bind to the top level
module ikp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [ikp_pkg::SHOULDER_W-1:0] rsp_shoulder_angle,
   input logic [ikp_pkg::ELBOW_W-1:0]           rsp_elbow_angle,
   input logic                                  rsp_out_of_reach
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_shoulder_angle) && $stable(rsp_elbow_angle)
                                  && $stable(rsp_out_of_reach))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("pipeline not empty after reset");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !$past(reset) |-> rsp_valid)
      else $error("req_ready low without pending results");

endmodule

bind two_link_planar_inverse_kinematics ikp_checker u_ikp_checker (.*);
